// File: design/lecp_pkg.sv
// Shared types and constants for the line edit and color command parser.
`default_nettype none
package lecp_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_RGB_MAX     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HUE_LIMIT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_MAX     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VAL_MAX     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DELETE_CODE = 3'd4;

	localparam logic [15:0] RST_RGB_MAX     = 16'd255;
	localparam logic [15:0] RST_HUE_LIMIT   = 16'd360;
	localparam logic [15:0] RST_SAT_MAX     = 16'd100;
	localparam logic [15:0] RST_VAL_MAX     = 16'd100;
	localparam logic [7:0]  RST_DELETE_CODE = 8'd127;

	localparam logic [1:0] ECHO_NONE   = 2'd0;
	localparam logic [1:0] ECHO_BYTE   = 2'd1;
	localparam logic [1:0] ECHO_CRLF   = 2'd2;
	localparam logic [1:0] ECHO_RUBOUT = 2'd3;

	localparam logic [1:0] CMD_UNKNOWN = 2'd0;
	localparam logic [1:0] CMD_RGB     = 2'd1;
	localparam logic [1:0] CMD_HSV     = 2'd2;
	localparam logic [1:0] CMD_HELP    = 2'd3;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [7:0] RGB_CHARS  [3] = '{8'h52, 8'h47, 8'h42};
	localparam logic [7:0] HSV_CHARS  [3] = '{8'h48, 8'h53, 8'h56};
	localparam logic [7:0] HELP_CHARS [4] = '{8'h68, 8'h65, 8'h6C, 8'h70};

	typedef struct packed {
		logic [15:0] rgb_max;
		logic [15:0] hue_limit;
		logic [15:0] sat_max;
		logic [15:0] val_max;
	} lecp_limits_t;

	typedef struct packed {
		logic [1:0]  code;
		logic [15:0] first;
		logic [15:0] second;
		logic [15:0] third;
	} lecp_cmd_t;

endpackage
`default_nettype wire

// File: design/line_edit_color_command_parser.sv
// Top level: terminal line editor, line store, configuration registers and result register.
// Edit bytes (echo, delete, ignored): result valid in the cycle after transfer;
// one byte per cycle while the result side does not stall. Line end: RAM scan of the
// stored line, read drain, three step limit check and result load; input stalls until
// the result is loaded.
// Reset clears the line length and the result valid flag and restores register defaults.
`default_nettype none
module line_edit_color_command_parser #(
	parameter int LINE_CAPACITY = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           rx_valid,
	output logic                                rx_stall,
	input  wire logic [7:0]                     rx_byte,
	output logic                                res_valid,
	input  wire logic                           res_stall,
	output logic      [1:0]                     echo_action,
	output logic      [7:0]                     echo_byte,
	output logic                                line_done,
	output logic      [1:0]                     command_code,
	output logic      [15:0]                    first_value,
	output logic      [15:0]                    second_value,
	output logic      [15:0]                    third_value,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [lecp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                    cfg_data
);
	import lecp_pkg::*;

	localparam int LEN_W  = $clog2(LINE_CAPACITY);
	localparam int ADDR_W = $clog2(LINE_CAPACITY - 1);

	lecp_limits_t     limits_q;
	logic [7:0]       del_code_q;
	logic [LEN_W-1:0] len_q;
	logic             res_valid_q;
	logic [1:0]       action_q;
	logic [7:0]       echo_q;
	logic             done_q;
	lecp_cmd_t        res_cmd_q;

	logic              acc;
	logic              is_eol;
	logic              is_del;
	logic              room;
	logic              wr_en;
	logic              take;
	logic              p_busy;
	logic              p_done;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;
	lecp_cmd_t         p_cmd;

	assign cfg_ready = 1'b1;
	assign take      = !res_valid_q || !res_stall;
	assign rx_stall  = p_busy || (res_valid_q && res_stall);
	assign acc       = rx_valid && !rx_stall;
	assign is_eol    = (rx_byte == CH_CR) || (rx_byte == CH_LF);
	assign is_del    = (rx_byte == del_code_q) || (rx_byte == CH_BS);
	assign room      = (len_q != LEN_W'(LINE_CAPACITY - 1));
	assign wr_en     = acc && !is_eol && !is_del && room;

	assign res_valid    = res_valid_q;
	assign echo_action  = action_q;
	assign echo_byte    = echo_q;
	assign line_done    = done_q;
	assign command_code = res_cmd_q.code;
	assign first_value  = res_cmd_q.first;
	assign second_value = res_cmd_q.second;
	assign third_value  = res_cmd_q.third;

	lecp_ram #(.WIDTH(8), .DEPTH(LINE_CAPACITY - 1)) u_line_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (len_q[ADDR_W-1:0]),
		.wdata (rx_byte),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	lecp_parser #(.LINE_CAPACITY(LINE_CAPACITY)) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (acc && is_eol),
		.len     (len_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.limits  (limits_q),
		.take    (take),
		.busy    (p_busy),
		.done    (p_done),
		.cmd     (p_cmd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.rgb_max   <= RST_RGB_MAX;
			limits_q.hue_limit <= RST_HUE_LIMIT;
			limits_q.sat_max   <= RST_SAT_MAX;
			limits_q.val_max   <= RST_VAL_MAX;
			del_code_q         <= RST_DELETE_CODE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RGB_MAX:     limits_q.rgb_max   <= cfg_data;
				REG_HUE_LIMIT:   limits_q.hue_limit <= cfg_data;
				REG_SAT_MAX:     limits_q.sat_max   <= cfg_data;
				REG_VAL_MAX:     limits_q.val_max   <= cfg_data;
				REG_DELETE_CODE: del_code_q         <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (acc) begin
			if (is_eol) len_q <= '0;
			else if (is_del) begin
				if (len_q != '0) len_q <= len_q - 1'b1;
			end else if (room) len_q <= len_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (acc && !is_eol) begin
			res_valid_q <= 1'b1;
		end else if (p_done && take) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !is_eol) begin
			done_q    <= 1'b0;
			res_cmd_q <= '{code: CMD_UNKNOWN, first: '0, second: '0, third: '0};
			if (is_del) begin
				action_q <= ECHO_RUBOUT;
				echo_q   <= '0;
			end else if (room) begin
				action_q <= ECHO_BYTE;
				echo_q   <= rx_byte;
			end else begin
				action_q <= ECHO_NONE;
				echo_q   <= '0;
			end
		end else if (p_done && take) begin
			action_q  <= ECHO_CRLF;
			echo_q    <= '0;
			done_q    <= 1'b1;
			res_cmd_q <= p_cmd;
		end
	end

endmodule
`default_nettype wire

// File: design/lecp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lecp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 15,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: design/lecp_parser.sv
// Line parser: walks the stored line through one digit accumulator and one limit comparator.
`default_nettype none
module lecp_parser #(
	parameter int LINE_CAPACITY = 16,
	localparam int LEN_W = $clog2(LINE_CAPACITY),
	localparam int ADDR_W = $clog2(LINE_CAPACITY - 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [LEN_W-1:0]       len,
	output logic                        rd_en,
	output logic      [ADDR_W-1:0]      rd_addr,
	input  wire logic [7:0]             rd_data,
	input  wire lecp_pkg::lecp_limits_t limits,
	input  wire logic                   take,
	output logic                        busy,
	output logic                        done,
	output lecp_pkg::lecp_cmd_t         cmd
);
	import lecp_pkg::*;

	typedef enum logic [1:0] {P_IDLE, P_SCAN, P_CHECK, P_DONE} pstate_t;

	pstate_t          state_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] rd_pos_q;
	logic [LEN_W-1:0] ev_pos_q;
	logic             ev_valid_q;
	logic             rgb_q;
	logic             hsv_q;
	logic             help_q;
	logic             fail_q;
	logic             ok_q;
	logic [1:0]       grp_q;
	logic [1:0]       chk_idx_q;
	logic [15:0]      val_q [3];
	lecp_cmd_t        cmd_q;

	logic        is_digit;
	logic        is_space;
	logic [1:0]  acc_sel;
	logic [15:0] acc_in;
	logic [15:0] acc_out;
	logic [15:0] cmp_a;
	logic [15:0] cmp_lim;
	logic        cmp_strict;
	logic        cmp_pass;
	logic        ok_final;

	assign rd_en   = (state_q == P_SCAN) && (rd_pos_q != len_q);
	assign rd_addr = rd_pos_q[ADDR_W-1:0];
	assign busy    = (state_q != P_IDLE);
	assign done    = (state_q == P_DONE);
	assign cmd     = cmd_q;

	assign is_digit = (rd_data >= CH_ZERO) && (rd_data <= CH_NINE);
	assign is_space = (rd_data == CH_SPACE);

	// value = value * 10 + digit, wrapping at 16 bits
	assign acc_sel = (grp_q == 2'd0) ? 2'd0 : grp_q - 2'd1;
	always_comb begin
		unique case (acc_sel)
			2'd0:    acc_in = val_q[0];
			2'd1:    acc_in = val_q[1];
			default: acc_in = val_q[2];
		endcase
	end
	assign acc_out = (acc_in << 3) + (acc_in << 1) + {12'd0, rd_data[3:0]};

	always_comb begin
		unique case (chk_idx_q)
			2'd0: begin
				cmp_a      = val_q[0];
				cmp_lim    = hsv_q ? limits.hue_limit : limits.rgb_max;
				cmp_strict = hsv_q;
			end
			2'd1: begin
				cmp_a      = val_q[1];
				cmp_lim    = hsv_q ? limits.sat_max : limits.rgb_max;
				cmp_strict = 1'b0;
			end
			default: begin
				cmp_a      = val_q[2];
				cmp_lim    = hsv_q ? limits.val_max : limits.rgb_max;
				cmp_strict = 1'b0;
			end
		endcase
	end
	assign cmp_pass = (cmp_a < cmp_lim) || (!cmp_strict && (cmp_a == cmp_lim));
	assign ok_final = ok_q && cmp_pass;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= P_IDLE;
			ev_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				P_IDLE: begin
					if (start) begin
						state_q    <= P_SCAN;
						len_q      <= len;
						rd_pos_q   <= '0;
						ev_valid_q <= 1'b0;
						rgb_q      <= (32'(len) >= 32'd3);
						hsv_q      <= (32'(len) >= 32'd3);
						help_q     <= (32'(len) == 32'd4);
						fail_q     <= 1'b0;
						grp_q      <= 2'd0;
						val_q[0]   <= '0;
						val_q[1]   <= '0;
						val_q[2]   <= '0;
					end
				end
				P_SCAN: begin
					if (rd_en) begin
						rd_pos_q   <= rd_pos_q + 1'b1;
						ev_pos_q   <= rd_pos_q;
						ev_valid_q <= 1'b1;
					end else begin
						ev_valid_q <= 1'b0;
					end
					if (ev_valid_q) begin
						if (ev_pos_q < LEN_W'(3)) begin
							if (rd_data != RGB_CHARS[ev_pos_q[1:0]]) rgb_q <= 1'b0;
							if (rd_data != HSV_CHARS[ev_pos_q[1:0]]) hsv_q <= 1'b0;
						end else if (is_space) begin
							if (grp_q == 2'd3) fail_q <= 1'b1;
							else grp_q <= grp_q + 2'd1;
						end else if (is_digit) begin
							if (grp_q == 2'd0) fail_q <= 1'b1;
							else val_q[acc_sel] <= acc_out;
						end else begin
							fail_q <= 1'b1;
						end
						if (32'(ev_pos_q) < 32'd4) begin
							if (rd_data != HELP_CHARS[ev_pos_q[1:0]]) help_q <= 1'b0;
						end
					end
					if (!rd_en && !ev_valid_q) begin
						state_q   <= P_CHECK;
						chk_idx_q <= 2'd0;
						ok_q      <= (rgb_q || hsv_q) && !fail_q && (grp_q == 2'd3);
					end
				end
				P_CHECK: begin
					ok_q      <= ok_final;
					chk_idx_q <= chk_idx_q + 2'd1;
					if (chk_idx_q == 2'd2) begin
						state_q <= P_DONE;
						if (help_q) begin
							cmd_q <= '{code: CMD_HELP, first: '0, second: '0, third: '0};
						end else if (ok_final) begin
							cmd_q <= '{code: rgb_q ? CMD_RGB : CMD_HSV,
								first: val_q[0], second: val_q[1], third: val_q[2]};
						end else begin
							cmd_q <= '{code: CMD_UNKNOWN, first: '0, second: '0, third: '0};
						end
					end
				end
				P_DONE: begin
					if (take) state_q <= P_IDLE;
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: design/lecp_checker.sv
// Port checker for the line edit and color command parser, bound to the top level.
`default_nettype none
module lecp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_stall,
	input wire logic [1:0]  echo_action,
	input wire logic [7:0]  echo_byte,
	input wire logic        line_done,
	input wire logic [1:0]  command_code,
	input wire logic [15:0] first_value,
	input wire logic [15:0] second_value,
	input wire logic [15:0] third_value
);
	import lecp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(echo_action) && $stable(echo_byte)
			&& $stable(line_done) && $stable(command_code) && $stable(first_value))
		else $error("result changed while stalled");

	a_done_crlf: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (line_done == (echo_action == ECHO_CRLF)))
		else $error("line end and CRLF echo disagree");

	a_edit_nocmd: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !line_done |-> command_code == CMD_UNKNOWN && first_value == '0
			&& second_value == '0 && third_value == '0)
		else $error("command reported without line end");

	a_cmd_values: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (command_code == CMD_UNKNOWN || command_code == CMD_HELP)
			|-> first_value == '0 && second_value == '0 && third_value == '0
				&& (echo_action == ECHO_BYTE || echo_byte == '0))
		else $error("values or echo byte set without a color command");

endmodule

bind line_edit_color_command_parser lecp_checker u_lecp_checker (.*);
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the line edit and color command parser, directed and random lines.
module testbench;
	import lecp_pkg::*;

	localparam int LINE_MAX       = 15;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int END_CYCLES     = 40;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] ch;
		logic       done;
		lecp_cmd_t  cmd;
	} echo_result_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 rx_valid  = 1'b0;
	logic                 rx_stall;
	logic [7:0]           rx_byte   = 8'h00;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic [1:0]           echo_action;
	logic [7:0]           echo_byte;
	logic                 line_done;
	logic [1:0]           command_code;
	logic [15:0]          first_value;
	logic [15:0]          second_value;
	logic [15:0]          third_value;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data  = 16'h0000;

	// line editor shadow state
	logic [7:0]  line_chars [LINE_MAX];
	int          line_len;
	logic [15:0] lim_rgb, lim_hue, lim_sat, lim_val;
	logic [7:0]  del_code;

	echo_result_t pending_echo_q [$];
	int fail_count   = 0;
	int bytes_sent   = 0;
	int idle_cycles  = 0;
	int tx_gap_max   = 10;
	int rx_stall_max = 10;

	always #2 clk = ~clk;

	line_edit_color_command_parser u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_byte      (rx_byte),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.echo_action  (echo_action),
		.echo_byte    (echo_byte),
		.line_done    (line_done),
		.command_code (command_code),
		.first_value  (first_value),
		.second_value (second_value),
		.third_value  (third_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	function automatic lecp_cmd_t decode_line();
		lecp_cmd_t   r;
		logic [15:0] num [3];
		logic [15:0] acc;
		int          pos, cnt, i;
		bit          rgb_word, hsv_word, help_word;
		r = '0;
		num[0] = '0;
		num[1] = '0;
		num[2] = '0;
		rgb_word = (line_len >= 3);
		hsv_word = (line_len >= 3);
		for (i = 0; i < 3; i++) begin
			if (line_chars[i] !== RGB_CHARS[i]) rgb_word = 1'b0;
			if (line_chars[i] !== HSV_CHARS[i]) hsv_word = 1'b0;
		end
		if (rgb_word || hsv_word) begin
			pos = 3;
			cnt = 0;
			while (pos < line_len && line_chars[pos] == CH_SPACE && cnt < 3) begin
				acc = '0;
				pos++;
				while (pos < line_len && line_chars[pos] >= CH_ZERO
						&& line_chars[pos] <= CH_NINE) begin
					acc = 16'(acc * 16'd10 + 16'(line_chars[pos] - CH_ZERO));
					pos++;
				end
				num[cnt] = acc;
				cnt++;
			end
			if (cnt == 3 && pos == line_len) begin
				if (rgb_word && num[0] <= lim_rgb && num[1] <= lim_rgb
						&& num[2] <= lim_rgb) begin
					r.code = CMD_RGB;
				end else if (hsv_word && num[0] < lim_hue && num[1] <= lim_sat
						&& num[2] <= lim_val) begin
					r.code = CMD_HSV;
				end
				if (r.code != CMD_UNKNOWN) begin
					r.first  = num[0];
					r.second = num[1];
					r.third  = num[2];
				end
			end
		end else if (line_len == 4) begin
			help_word = 1'b1;
			for (i = 0; i < 4; i++)
				if (line_chars[i] !== HELP_CHARS[i]) help_word = 1'b0;
			if (help_word) r.code = CMD_HELP;
		end
		return r;
	endfunction

	function automatic echo_result_t line_editor_step(logic [7:0] b);
		echo_result_t r;
		r = '0;
		if (b == CH_CR || b == CH_LF) begin
			r.action = ECHO_CRLF;
			r.done   = 1'b1;
			r.cmd    = decode_line();
			line_len = 0;
		end else if (b == del_code || b == CH_BS) begin
			r.action = ECHO_RUBOUT;
			if (line_len > 0) line_len--;
		end else if (line_len < LINE_MAX) begin
			r.action = ECHO_BYTE;
			r.ch     = b;
			line_chars[line_len] = b;
			line_len++;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		fail_count++;
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	task automatic check_result();
		echo_result_t e;
		if (pending_echo_q.size() == 0) begin
			report_mismatch("result with nothing pending", echo_action, 16'h0000);
			return;
		end
		e = pending_echo_q.pop_front();
		if (echo_action !== e.action) report_mismatch("echo_action", echo_action, e.action);
		if (echo_byte !== e.ch) report_mismatch("echo_byte", echo_byte, e.ch);
		if (line_done !== e.done) report_mismatch("line_done", line_done, e.done);
		if (command_code !== e.cmd.code) report_mismatch("command_code", command_code, e.cmd.code);
		if (first_value !== e.cmd.first) report_mismatch("first_value", first_value, e.cmd.first);
		if (second_value !== e.cmd.second)
			report_mismatch("second_value", second_value, e.cmd.second);
		if (third_value !== e.cmd.third) report_mismatch("third_value", third_value, e.cmd.third);
	endtask

	task automatic send_byte(input logic [7:0] b);
		int           gap;
		echo_result_t r;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (rx_stall !== 1'b0);
		r = line_editor_step(b);
		pending_echo_q.push_back(r);
		if (r.action != ECHO_NONE) bytes_sent++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	// sender holds off until the block has answered every byte
	task automatic drain_results();
		rx_valid <= 1'b0;
		while (pending_echo_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_RGB_MAX:     lim_rgb  = data;
			REG_HUE_LIMIT:   lim_hue  = data;
			REG_SAT_MAX:     lim_sat  = data;
			REG_VAL_MAX:     lim_val  = data;
			REG_DELETE_CODE: del_code = data[7:0];
			default: ;
		endcase
	endtask

	task automatic apply_limits(input logic [15:0] rgb, input logic [15:0] hue,
			input logic [15:0] sat, input logic [15:0] val, input logic [7:0] del);
		drain_results();
		write_reg(REG_RGB_MAX, rgb);
		write_reg(REG_HUE_LIMIT, hue);
		write_reg(REG_SAT_MAX, sat);
		write_reg(REG_VAL_MAX, val);
		write_reg(REG_DELETE_CODE, {8'h00, del});
		cfg_valid <= 1'b0;
	endtask

	function automatic string number_text(logic [15:0] limit);
		case ($urandom_range(0, 7))
			0: return "";
			1: return $sformatf("%0d", limit);
			2: return $sformatf("%0d", int'(limit) + 1);
			3: return $sformatf("%0d", 16'(limit - 16'd1));
			4: return $sformatf("%0d", $urandom_range(0, 999));
			5: return $sformatf("%0d", $urandom_range(0, 65535));
			6: return $sformatf("00%0d", $urandom_range(0, 9));
			default: return $sformatf("%0d", $urandom_range(65536, 999999));
		endcase
	endfunction

	task automatic send_random_line();
		logic [7:0] q [$];
		logic [7:0] rub;
		string      s, word;
		int         kind, i, n;
		bit         hsv;
		logic [15:0] l0, l1, l2;
		kind = $urandom_range(0, 99);
		hsv  = $urandom_range(0, 1);
		word = hsv ? "HSV" : "RGB";
		l0   = hsv ? lim_hue : lim_rgb;
		l1   = hsv ? lim_sat : lim_rgb;
		l2   = hsv ? lim_val : lim_rgb;
		s    = "";
		if (kind < 50) begin
			s = {word, " ", number_text(l0), " ", number_text(l1), " ", number_text(l2)};
		end else if (kind < 60) begin
			s = "help";
		end else if (kind < 75) begin
			case ($urandom_range(0, 4))
				0: s = {word, " ", number_text(l0), " ", number_text(l1)};
				1: s = {word, " 1 2 3", ($urandom_range(0, 1) ? " " : "x")};
				2: s = hsv ? "hsv 1 2 3" : "rgb 1 2 3";
				3: s = $urandom_range(0, 1) ? "help " : "hel";
				default: s = {word, "1 2 3"};
			endcase
		end
		if (kind < 75) begin
			for (i = 0; i < s.len(); i++) begin
				q.push_back(s[i]);
				if ($urandom_range(0, 11) == 0) begin
					rub = (del_code == CH_CR || del_code == CH_LF || $urandom_range(0, 1))
						? CH_BS : del_code;
					q.push_back(8'($urandom_range(8'h21, 8'h7E)));
					q.push_back(rub);
				end
			end
		end else if (kind < 90) begin
			n = $urandom_range(0, 20);
			repeat (n) q.push_back(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(LINE_MAX, LINE_MAX + 5);
			repeat (n) q.push_back(8'($urandom_range(8'h21, 8'h7E)));
			if ($urandom_range(0, 1)) q.push_back(CH_BS);
		end
		q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
		foreach (q[i]) send_byte(q[i]);
	endtask

	task automatic run_random_lines(input int count);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < count) send_random_line();
	endtask

	task automatic test_directed_cases();
		send_byte(CH_BS);
		send_byte(RST_DELETE_CODE);
		send_text("help");
		send_byte(CH_LF);
		send_text("RGB 255  ");
		send_byte(CH_CR);
		send_byte(8'h00);
		send_byte(CH_CR);
		send_byte(CH_CR);
		repeat (LINE_MAX) send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(CH_BS);
		send_byte(CH_CR);
	endtask

	task automatic test_terminator_precedence();
		apply_limits(RST_RGB_MAX, RST_HUE_LIMIT, RST_SAT_MAX, RST_VAL_MAX, CH_CR);
		send_text("help");
		send_byte(CH_CR);
		apply_limits(RST_RGB_MAX, RST_HUE_LIMIT, RST_SAT_MAX, RST_VAL_MAX, CH_LF);
		send_text("HSV 1 2 3");
		send_byte(CH_LF);
		apply_limits(RST_RGB_MAX, RST_HUE_LIMIT, RST_SAT_MAX, RST_VAL_MAX, 8'h00);
		send_text("helpx");
		send_byte(8'h00);
		send_byte(CH_CR);
		apply_limits(RST_RGB_MAX, RST_HUE_LIMIT, RST_SAT_MAX, RST_VAL_MAX, RST_DELETE_CODE);
	endtask

	task automatic test_unknown_index();
		int i;
		drain_results();
		for (i = int'(REG_DELETE_CODE) + 1; i < 2 ** CFG_IDX_W; i++)
			write_reg(CFG_IDX_W'(i), 16'h0000);
		cfg_valid <= 1'b0;
		send_text("RGB 1 1 1");
		send_byte(CH_CR);
		send_text("HSV 1 1 1");
		send_byte(CH_LF);
	endtask

	task automatic test_back_to_back();
		drain_results();
		tx_gap_max   = 0;
		rx_stall_max = 0;
		run_random_lines(40);
		drain_results();
		tx_gap_max   = 10;
		rx_stall_max = 10;
	endtask

	task automatic test_random_defaults();
		apply_limits(RST_RGB_MAX, RST_HUE_LIMIT, RST_SAT_MAX, RST_VAL_MAX, RST_DELETE_CODE);
		run_random_lines(80);
		drain_results();
		run_random_lines(80);
	endtask

	task automatic test_random_wide_limits();
		apply_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
		run_random_lines(110);
	endtask

	task automatic test_random_zero_limits();
		apply_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		run_random_lines(80);
	endtask

	task automatic test_random_mixed_limits();
		logic [7:0] del;
		repeat (3) begin
			case ($urandom_range(0, 3))
				0: del = 8'($urandom_range(0, 255));
				1: del = CH_SPACE;
				2: del = 8'(CH_ZERO + $urandom_range(0, 9));
				default: del = RST_DELETE_CODE;
			endcase
			apply_limits(16'($urandom_range(0, 999)), 16'($urandom_range(0, 999)),
				16'($urandom_range(0, 999)), 16'($urandom_range(0, 999)), del);
			run_random_lines(50);
		end
	endtask

	// result side: random stall per transfer, then check
	initial begin
		int hold;
		forever begin
			hold = $urandom_range(0, rx_stall_max);
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (res_valid !== 1'b1);
			check_result();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (rx_valid && !rx_stall) || (res_valid && !res_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		lim_rgb  = RST_RGB_MAX;
		lim_hue  = RST_HUE_LIMIT;
		lim_sat  = RST_SAT_MAX;
		lim_val  = RST_VAL_MAX;
		del_code = RST_DELETE_CODE;
		line_len = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_terminator_precedence();
		test_unknown_index();
		test_back_to_back();
		test_random_defaults();
		test_random_wide_limits();
		test_random_zero_limits();
		test_random_mixed_limits();
		drain_results();
		repeat (END_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
